FILE: design/feedback_delay_line_assert.svh
// assertion helpers for the feedback delay line checker
`ifndef FEEDBACK_DELAY_LINE_ASSERT_SVH
`define FEEDBACK_DELAY_LINE_ASSERT_SVH

// trigger implies condition in the next cycle
`define FDL_ASSERT_NEXT(label, trig, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cond)) \
      else $error(msg);

// trigger implies signal unchanged in the next cycle
`define FDL_ASSERT_HOLD(label, trig, sig, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |=> $stable(sig)) \
      else $error(msg);

`endif

FILE: design/fdl_pkg.sv
package fdl_pkg;

   localparam int BUFFER_DEPTH_DEFAULT  = 1024;
   localparam int SAMPLE_BITS_DEFAULT   = 16;
   localparam int FRACTION_BITS_DEFAULT = 8;

   localparam int DELAY_BITS     = 18;
   localparam int GAIN_BITS      = 16;
   localparam int GAIN_SHIFT     = 15;
   localparam int CSR_INDEX_BITS = 2;

   localparam logic [DELAY_BITS-1:0]       DELAY_RESET    = '0;
   localparam logic signed [GAIN_BITS-1:0] FEEDBACK_RESET = 16'sd0;
   localparam logic signed [GAIN_BITS-1:0] DRY_RESET      = 16'sd32767;
   localparam logic signed [GAIN_BITS-1:0] WET_RESET      = 16'sd16384;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_DELAY_LENGTH  = 2'd0,
      CSR_FEEDBACK_GAIN = 2'd1,
      CSR_DRY_GAIN      = 2'd2,
      CSR_WET_GAIN      = 2'd3
   } csr_index_type;

endpackage

FILE: design/fdl_delay_mod.sv
module fdl_delay_mod #(
   parameter int BUFFER_DEPTH  = fdl_pkg::BUFFER_DEPTH_DEFAULT,
   parameter int FRACTION_BITS = fdl_pkg::FRACTION_BITS_DEFAULT
) (
   input  logic                                          clock,
   input  logic [fdl_pkg::DELAY_BITS-FRACTION_BITS-1:0]  delay_int,
   output logic [$clog2(BUFFER_DEPTH)-1:0]               delay_mod
);

   localparam int IW   = fdl_pkg::DELAY_BITS - FRACTION_BITS;
   localparam int LW   = $clog2(BUFFER_DEPTH);
   localparam int SH   = IW + LW;
   localparam int MW   = IW + 2;
   localparam int PW   = SH + IW;
   localparam int RW   = IW + LW + 1;
   localparam logic [63:0] RECIP =
      ((64'd1 << SH) + 64'(BUFFER_DEPTH) - 64'd1) / 64'(BUFFER_DEPTH);

   logic [PW-1:0] quot_prod;
   logic [IW-1:0] quot_ff;
   logic [IW-1:0] num_ff;
   logic [RW-1:0] rem_full;
   logic [LW-1:0] mod_ff;

   // reciprocal multiply gives the exact quotient for every value of the integer part
   assign quot_prod = PW'(delay_int) * PW'(RECIP[MW-1:0]);
   assign rem_full  = RW'(num_ff) - RW'(quot_ff) * RW'(BUFFER_DEPTH);

   always_ff @(posedge clock) begin
      num_ff  <= delay_int;
      quot_ff <= quot_prod[SH +: IW];
      mod_ff  <= rem_full[LW-1:0];
   end

   assign delay_mod = mod_ff;

endmodule

FILE: design/feedback_delay_line.sv
// feedback delay line with linear interpolation
//
// req_ beat carries one signed sample; rsp_ beat returns the mix of the
// input and the fractionally delayed sample. csr_ writes the delay (Q.8
// fraction), the feedback gain and the dry and wet gains, one per cycle.
//
// a taken request beat passes ST_RD_OLD, ST_INTERP, ST_MULT and ST_MIX into
// the output register. one sample is in flight at a time: a new request is
// taken only after the last has passed the single read port of the delay
// store (newer tap, then older tap), the interpolation multiply, the gain
// multiplies and the mix and write-back stage. after a csr write, req_stall
// stays high while the delay index is reduced modulo the depth.
//
// reset: synchronous; the delay store is cleared one entry per cycle, so
// req_stall stays high after reset is released until every entry is cleared.
// csr writes are taken during that pass.
//
// rsp_stall: the result waits in the output register; the next request is
// still taken, and its result holds in the mix stage until the output frees.
module feedback_delay_line #(
   parameter int BUFFER_DEPTH  = fdl_pkg::BUFFER_DEPTH_DEFAULT,
   parameter int SAMPLE_BITS   = fdl_pkg::SAMPLE_BITS_DEFAULT,
   parameter int FRACTION_BITS = fdl_pkg::FRACTION_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [SAMPLE_BITS-1:0]       req_sample_in,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [SAMPLE_BITS-1:0]       rsp_sample_out,
   input  logic                                csr_write,
   input  logic [fdl_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [fdl_pkg::DELAY_BITS-1:0]      csr_data
);

   localparam int SB   = SAMPLE_BITS;
   localparam int GB   = fdl_pkg::GAIN_BITS;
   localparam int AW   = $clog2(BUFFER_DEPTH);
   localparam int IW   = fdl_pkg::DELAY_BITS - FRACTION_BITS;
   localparam int PIW  = SB + FRACTION_BITS + 2;
   localparam int PW   = SB + GB;
   localparam int MXW  = SB + GB + 1;
   localparam logic signed [PIW-1:0] INTERP_HALF = PIW'(1) <<< (FRACTION_BITS - 1);
   localparam logic signed [MXW-1:0] GAIN_HALF   = MXW'(1) <<< (fdl_pkg::GAIN_SHIFT - 1);
   localparam logic [AW-1:0]         LAST_ADDR   = AW'(BUFFER_DEPTH - 1);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_RD_OLD,
      ST_INTERP,
      ST_MULT,
      ST_MIX
   } state_type;

   function automatic logic [SB-1:0] saturate(input logic signed [MXW-1:0] v);
      logic [MXW-SB:0] upper;
      upper = v[MXW-1:SB-1];
      if ((&upper) || !(|upper)) begin
         return v[SB-1:0];
      end else if (v[MXW-1]) begin
         return {1'b1, {(SB-1){1'b0}}};
      end else begin
         return {1'b0, {(SB-1){1'b1}}};
      end
   endfunction

   state_type                   state_ff, state_in;
   logic [AW-1:0]               wp_ff, wp_in;
   logic [AW-1:0]               clr_ff, clr_in;
   logic [1:0]                  settle_ff, settle_in;
   logic [AW-1:0]               inew_ff, inew_in;
   logic signed [SB-1:0]        x_ff, x_in;
   logic [SB-1:0]               rd_data_ff;
   logic signed [SB-1:0]        b_new_ff, b_new_in;
   logic signed [SB-1:0]        delayed_ff, delayed_in;
   logic signed [PW-1:0]        p_dry_ff, p_dry_in;
   logic signed [PW-1:0]        p_wet_ff, p_wet_in;
   logic signed [PW-1:0]        p_fb_ff, p_fb_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic signed [SB-1:0]        rsp_out_ff, rsp_out_in;

   logic [fdl_pkg::DELAY_BITS-1:0]  delay_ff;
   logic signed [GB-1:0]            fb_gain_ff;
   logic signed [GB-1:0]            dry_gain_ff;
   logic signed [GB-1:0]            wet_gain_ff;

   logic [SB-1:0]               mem [BUFFER_DEPTH];
   logic                        mem_we;
   logic [AW-1:0]               mem_waddr;
   logic [SB-1:0]               mem_wdata;
   logic [AW-1:0]               rd_addr;

   logic [AW-1:0]               delay_mod;
   logic [AW:0]                 ptr_diff;
   logic [AW:0]                 ptr_wrap;
   logic [AW-1:0]               i_new;
   logic [AW-1:0]               i_old;
   logic                        accept;
   logic                        mix_go;

   logic signed [SB:0]          tap_diff;
   logic signed [PIW-1:0]       interp_prod;
   logic signed [PIW-1:0]       interp_term;
   logic signed [PIW-1:0]       delayed_sum;
   logic signed [MXW-1:0]       mix_sum;
   logic signed [MXW-1:0]       fb_term;
   logic signed [MXW-1:0]       back_sum;
   logic [SB-1:0]               back_sat;

   fdl_delay_mod #(
      .BUFFER_DEPTH  (BUFFER_DEPTH),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_delay_mod (
      .clock     (clock),
      .delay_int (delay_ff[fdl_pkg::DELAY_BITS-1 -: IW]),
      .delay_mod (delay_mod)
   );

   assign req_stall = !((state_ff == ST_IDLE) && (settle_ff == 2'd0));
   assign accept    = req_valid && !req_stall;
   assign mix_go    = (state_ff == ST_MIX) && (!rsp_valid_ff || !rsp_stall);

   // read pointers, wrapped into the store
   assign ptr_diff = {1'b0, wp_ff} - {1'b0, delay_mod};
   assign ptr_wrap = {1'b0, wp_ff} + (AW+1)'(BUFFER_DEPTH) - {1'b0, delay_mod};
   assign i_new    = ptr_diff[AW] ? ptr_wrap[AW-1:0] : ptr_diff[AW-1:0];
   assign i_old    = (inew_ff == '0) ? LAST_ADDR : inew_ff - AW'(1);
   assign rd_addr  = (state_ff == ST_RD_OLD) ? i_old : i_new;

   // interpolation between the two taps
   assign tap_diff    = $signed({rd_data_ff[SB-1], rd_data_ff}) - (SB+1)'(b_new_ff);
   assign interp_prod = PIW'(tap_diff) * PIW'($signed({1'b0, delay_ff[FRACTION_BITS-1:0]}));
   assign interp_term = (interp_prod + INTERP_HALF) >>> FRACTION_BITS;
   assign delayed_sum = PIW'(b_new_ff) + interp_term;

   // mix and write-back
   assign mix_sum  = (MXW'(p_dry_ff) + MXW'(p_wet_ff) + GAIN_HALF) >>> fdl_pkg::GAIN_SHIFT;
   assign fb_term  = (MXW'(p_fb_ff) + GAIN_HALF) >>> fdl_pkg::GAIN_SHIFT;
   assign back_sum = fb_term + MXW'(x_ff);
   assign back_sat = saturate(back_sum);

   assign mem_we    = (state_ff == ST_CLEAR) || mix_go;
   assign mem_waddr = (state_ff == ST_CLEAR) ? clr_ff : wp_ff;
   assign mem_wdata = (state_ff == ST_CLEAR) ? '0 : back_sat;

   always_comb begin
      state_in     = state_ff;
      wp_in        = wp_ff;
      clr_in       = clr_ff;
      inew_in      = inew_ff;
      x_in         = x_ff;
      b_new_in     = b_new_ff;
      delayed_in   = delayed_ff;
      p_dry_in     = p_dry_ff;
      p_wet_in     = p_wet_ff;
      p_fb_in      = p_fb_ff;
      rsp_out_in   = rsp_out_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      if (csr_write) begin
         settle_in = 2'd2;
      end else if (settle_ff != 2'd0) begin
         settle_in = settle_ff - 2'd1;
      end else begin
         settle_in = settle_ff;
      end

      case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + AW'(1);
            if (clr_ff == LAST_ADDR) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            inew_in = i_new;
            if (accept) begin
               x_in     = req_sample_in;
               state_in = ST_RD_OLD;
            end
         end
         ST_RD_OLD: begin
            b_new_in = $signed(rd_data_ff);
            state_in = ST_INTERP;
         end
         ST_INTERP: begin
            delayed_in = delayed_sum[SB-1:0];
            state_in   = ST_MULT;
         end
         ST_MULT: begin
            p_dry_in = PW'(x_ff) * PW'(dry_gain_ff);
            p_wet_in = PW'(delayed_ff) * PW'(wet_gain_ff);
            p_fb_in  = PW'(delayed_ff) * PW'(fb_gain_ff);
            state_in = ST_MIX;
         end
         ST_MIX: begin
            if (mix_go) begin
               rsp_out_in   = saturate(mix_sum);
               rsp_valid_in = 1'b1;
               wp_in        = (wp_ff == LAST_ADDR) ? '0 : wp_ff + AW'(1);
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         wp_ff        <= '0;
         clr_ff       <= '0;
         settle_ff    <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         clr_ff       <= clr_in;
         settle_ff    <= settle_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      inew_ff    <= inew_in;
      x_ff       <= x_in;
      b_new_ff   <= b_new_in;
      delayed_ff <= delayed_in;
      p_dry_ff   <= p_dry_in;
      p_wet_ff   <= p_wet_in;
      p_fb_ff    <= p_fb_in;
      rsp_out_ff <= rsp_out_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         delay_ff    <= fdl_pkg::DELAY_RESET;
         fb_gain_ff  <= fdl_pkg::FEEDBACK_RESET;
         dry_gain_ff <= fdl_pkg::DRY_RESET;
         wet_gain_ff <= fdl_pkg::WET_RESET;
      end else if (csr_write) begin
         case (fdl_pkg::csr_index_type'(csr_index))
            fdl_pkg::CSR_DELAY_LENGTH:  delay_ff    <= csr_data;
            fdl_pkg::CSR_FEEDBACK_GAIN: fb_gain_ff  <= $signed(csr_data[GB-1:0]);
            fdl_pkg::CSR_DRY_GAIN:      dry_gain_ff <= $signed(csr_data[GB-1:0]);
            fdl_pkg::CSR_WET_GAIN:      wet_gain_ff <= $signed(csr_data[GB-1:0]);
            default: begin
            end
         endcase
      end
   end

   // delay store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_out_ff;

endmodule

FILE: design/fdl_checker.sv
`include "feedback_delay_line_assert.svh"

module fdl_checker #(
   parameter int SAMPLE_BITS = fdl_pkg::SAMPLE_BITS_DEFAULT
) (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_stall,
   input logic                    rsp_valid,
   input logic                    rsp_stall,
   input logic [SAMPLE_BITS-1:0]  rsp_sample_out,
   input logic                    csr_write
);

   `FDL_ASSERT_NEXT(a_rsp_valid_holds, rsp_valid && rsp_stall, rsp_valid,
      "stalled response beat dropped")
   `FDL_ASSERT_HOLD(a_rsp_data_holds, rsp_valid && rsp_stall, rsp_sample_out,
      "stalled response beat changed")
   `FDL_ASSERT_NEXT(a_one_at_a_time, req_valid && !req_stall, req_stall,
      "request taken while a sample is in flight")
   `FDL_ASSERT_NEXT(a_csr_settle, csr_write, req_stall,
      "request taken before the delay index settled")
   `FDL_ASSERT_NEXT(a_no_early_rsp, req_valid && !req_stall, !$rose(rsp_valid),
      "response beat right after its request")

endmodule

bind feedback_delay_line fdl_checker #(
   .SAMPLE_BITS (SAMPLE_BITS)
) u_fdl_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_sample_out (rsp_sample_out),
   .csr_write      (csr_write)
);
